// File: hw/rtl/rvm_pkg.sv
package rvm_pkg;

  localparam int unsigned SQRT_STEPS   = 20;
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned REDUCE_STEPS = 5;

  localparam logic [31:0]        TWO_PI_Q28  = 32'd1686629713;
  localparam logic [31:0]        HALF_PI_Q28 = 32'd421657428;
  localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;
  localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;

  // Horner divisors, highest term first
  localparam int unsigned SIN_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

  // compare-subtract constants: reduce mod 2*pi, then quadrant split
  localparam logic [31:0] REDUCE_K [REDUCE_STEPS] = '{
    32'd3373259426, TWO_PI_Q28, 32'd1686629712, 32'd843314856, HALF_PI_Q28
  };

  typedef logic signed [15:0] q14_t;
  typedef logic signed [29:0] q28_t;
  typedef logic [28:0]        ang_t;

endpackage

// File: hw/rtl/rvm_sincos.sv
module rvm_sincos
  import rvm_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  ang_t        f,
  input  logic [29:0] f2,
  output q28_t        sin_f,
  output q28_t        cos_f
);

  q28_t        t    [2][HORNER_STEPS+1];
  ang_t        f_s  [HORNER_STEPS+1];
  logic [29:0] f2_s [HORNER_STEPS+1];

  assign f_s[0]  = f;
  assign f2_s[0] = f2;

  genvar i, j;
  for (j = 0; j < 2; j++) begin : g_init
    assign t[j][0] = q28_t'(ONE_Q28);
  end

  // three stages per term: multiply, reciprocal multiply, correct and update
  for (i = 0; i < HORNER_STEPS; i++) begin : g_step
    ang_t        fa, fb, fc;
    logic [29:0] f2a, f2b, f2c;

    always_ff @(posedge clk) begin
      if (en) begin
        fa  <= f_s[i];
        f2a <= f2_s[i];
        fb  <= fa;
        f2b <= f2a;
        fc  <= fb;
        f2c <= f2b;
      end
    end

    assign f_s[i+1]  = fc;
    assign f2_s[i+1] = f2c;

    for (j = 0; j < 2; j++) begin : g_lane
      localparam int unsigned DV   = (j == 0) ? SIN_DIV[i] : COS_DIV[i];
      localparam int unsigned SH   = 31 + $clog2(DV);
      localparam logic [63:0] RC_W = (64'd1 << SH) / DV;
      localparam logic [31:0] RC   = RC_W[31:0];
      localparam logic [30:0] DV_N = 31'(DV);

      logic signed [60:0] prod_full;
      logic signed [60:0] prod_a;
      logic [60:0]        mag;
      logic [30:0]        m_w;
      logic [62:0]        rm_full;
      logic [30:0]        m_b;
      logic               neg_b;
      logic [62:0]        rm_b;
      logic [62:0]        rm_sh;
      logic [30:0]        q0, qd, rem, q1;
      logic signed [32:0] qs, tn;
      q28_t               t_c;

      assign prod_full = t[j][i] * $signed({1'b0, f2_s[i]});
      assign mag       = prod_a[60] ? -prod_a : prod_a;
      assign m_w       = mag[58:28];
      assign rm_full   = m_w * RC;

      // reciprocal estimate is low by at most one
      assign rm_sh = rm_b >> SH;
      assign q0    = rm_sh[30:0];
      assign qd    = q0 * DV_N;
      assign rem   = m_b - qd;
      assign q1    = (rem >= DV_N) ? q0 + 31'd1 : q0;
      assign qs    = neg_b ? -$signed({2'b00, q1}) : $signed({2'b00, q1});
      assign tn    = 33'(ONE_Q28) - qs;

      always_ff @(posedge clk) begin
        if (en) begin
          prod_a <= prod_full;
          m_b    <= m_w;
          neg_b  <= prod_a[60];
          rm_b   <= rm_full;
          t_c    <= tn[29:0];
        end
      end

      assign t[j][i+1] = t_c;
    end
  end

  // sin = f * series, truncated toward zero
  logic [29:0] ts_abs;
  logic [57:0] sp_full;
  logic [57:0] sp;
  logic        sneg;
  q28_t        tc_f;
  logic [29:0] sp_sh;

  assign ts_abs  = t[0][HORNER_STEPS][29] ? 30'(-t[0][HORNER_STEPS]) : t[0][HORNER_STEPS];
  assign sp_full = f_s[HORNER_STEPS] * ts_abs[28:0];
  assign sp_sh   = sp[57:28];

  always_ff @(posedge clk) begin
    if (en) begin
      sp    <= sp_full;
      sneg  <= t[0][HORNER_STEPS][29];
      tc_f  <= t[1][HORNER_STEPS];
      sin_f <= sneg ? -$signed(sp_sh) : $signed(sp_sh);
      cos_f <= tc_f;
    end
  end

endmodule

// File: hw/rtl/rotation_vector_to_matrix_core.sv
// Rotation vector to 3x3 rotation matrix, Q3.12 in, Q1.14 out.
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// Depth is set by the 20-stage square root, the 18-stage Taylor series and 4 matrix stages.
// Reset (rst, synchronous): all valid bits cleared, small_angle_limit set to 1.
module rotation_vector_to_matrix_core
  import rvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rot_valid,
  output logic        rot_stall,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        mat_valid,
  input  logic        mat_stall,
  output q14_t        m00,
  output q14_t        m01,
  output q14_t        m02,
  output q14_t        m10,
  output q14_t        m11,
  output q14_t        m12,
  output q14_t        m20,
  output q14_t        m21,
  output q14_t        m22,
  output logic        identity_taken
);

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned U_DLY     = 9;
  localparam int unsigned SC_LAT    = 20;
  localparam int unsigned LAT       = 53;

  localparam int unsigned PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

  function automatic q14_t to_q14(input logic signed [61:0] v);
    logic [61:0] mag;
    logic [61:0] rnd;
    logic [19:0] r;
    mag = v[61] ? -v : v;
    rnd = mag + (62'd1 << 41);
    r   = rnd[61:42];
    if (r > 20'd16384) r = 20'd16384;
    return v[61] ? -$signed(r[15:0]) : $signed(r[15:0]);
  endfunction

  logic [31:0]    small_angle_limit;
  logic           en;
  logic [LAT-1:0] vld;

  assign cfg_ready = 1'b1;
  assign en        = !(vld[LAT-1] && mat_stall);
  assign rot_stall = !en;
  assign mat_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      small_angle_limit <= 32'd1;
    end else if (cfg_valid) begin
      small_angle_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], rot_valid};
    end
  end

  // squares, then squared norm and small-angle test
  logic signed [15:0] v1 [3];
  logic signed [31:0] sq_full [3];
  logic [31:0]        sq1 [3];
  logic [31:0]        n2_sum;
  logic [31:0]        n2;
  logic               id_n2;
  logic [47:0]        v2;

  assign sq_full[0] = rot_x * rot_x;
  assign sq_full[1] = rot_y * rot_y;
  assign sq_full[2] = rot_z * rot_z;
  assign n2_sum     = sq1[0] + sq1[1] + sq1[2];

  always_ff @(posedge clk) begin
    if (en) begin
      v1[0] <= rot_x;
      v1[1] <= rot_y;
      v1[2] <= rot_z;
      for (int k = 0; k < 3; k++) sq1[k] <= $unsigned(sq_full[k]);
      n2    <= n2_sum;
      id_n2 <= (n2_sum == 32'd0) || (n2_sum < small_angle_limit);
      v2    <= {v1[2], v1[1], v1[0]};
    end
  end

  // digit-by-digit square root of n2 * 2^8, one result bit per stage
  logic [22:0] sr_rem  [SQRT_STEPS];
  logic [19:0] sr_root [SQRT_STEPS];
  logic [39:0] sr_num  [SQRT_STEPS];
  logic [47:0] sr_v    [SQRT_STEPS];
  logic        sr_id   [SQRT_STEPS];

  genvar k, l, j, p;
  for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [22:0] rem_i;
    logic [19:0] root_i;
    logic [39:0] num_i;
    logic [47:0] v_i;
    logic        id_i;
    logic [22:0] rs, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign num_i  = {n2, 8'd0};
      assign v_i    = v2;
      assign id_i   = id_n2;
    end else begin : g_next
      assign rem_i  = sr_rem[k-1];
      assign root_i = sr_root[k-1];
      assign num_i  = sr_num[k-1];
      assign v_i    = sr_v[k-1];
      assign id_i   = sr_id[k-1];
    end

    assign rs    = {rem_i[20:0], num_i[39:38]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[k]  <= ge ? rs - trial : rs;
        sr_root[k] <= {root_i[18:0], ge};
        sr_num[k]  <= {num_i[37:0], 2'b00};
        sr_v[k]    <= v_i;
        sr_id[k]   <= id_i;
      end
    end
  end

  logic [19:0] ang_a;
  logic [47:0] ang_v;
  assign ang_a = sr_root[SQRT_STEPS-1];
  assign ang_v = sr_v[SQRT_STEPS-1];

  // unit axis: restoring division per lane, quotient above 16384 is clamped
  logic [34:0] dv_rem [3][DIV_STEPS+1];
  logic [15:0] dv_q   [3][DIV_STEPS+1];
  logic        dv_neg [3][DIV_STEPS+1];
  logic [19:0] dv_a   [DIV_STEPS+1];
  q14_t        u_fin  [3];
  q14_t        ud     [3][U_DLY];

  always_ff @(posedge clk) begin
    if (en) dv_a[0] <= ang_a;
  end

  for (l = 0; l < 3; l++) begin : g_dlane
    logic signed [15:0] vl;
    logic [15:0]        mag;
    logic [15:0]        qmag;
    assign vl  = ang_v[16*l +: 16];
    assign mag = vl[15] ? 16'(-vl) : vl;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[l][0] <= {1'b0, mag, 18'd0} + 35'(ang_a[19:1]);
        dv_q[l][0]   <= '0;
        dv_neg[l][0] <= vl[15];
      end
    end

    assign qmag = (dv_q[l][DIV_STEPS] > 16'd16384) ? 16'd16384 : dv_q[l][DIV_STEPS];

    always_ff @(posedge clk) begin
      if (en) u_fin[l] <= dv_neg[l][DIV_STEPS] ? -$signed(qmag) : $signed(qmag);
    end
  end

  for (j = 1; j <= DIV_STEPS; j++) begin : g_dstep
    localparam int unsigned KB = DIV_STEPS - j;
    always_ff @(posedge clk) begin
      if (en) dv_a[j] <= dv_a[j-1];
    end
    for (l = 0; l < 3; l++) begin : g_lane
      logic [34:0] trial;
      logic        ge;
      assign trial = 35'(dv_a[j-1]) << KB;
      assign ge    = dv_rem[l][j-1] >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[l][j] <= ge ? dv_rem[l][j-1] - trial : dv_rem[l][j-1];
          dv_q[l][j]   <= dv_q[l][j-1] | (ge ? (16'd1 << KB) : 16'd0);
          dv_neg[l][j] <= dv_neg[l][j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ud[a][0] <= u_fin[a];
        for (int b = 1; b < U_DLY; b++) ud[a][b] <= ud[a][b-1];
      end
    end
  end

  // angle reduction to [0, pi/2) plus quadrant
  logic [31:0] an_r [REDUCE_STEPS];
  logic [1:0]  an_q [REDUCE_STEPS];

  for (k = 0; k < REDUCE_STEPS; k++) begin : g_reduce
    logic [31:0] r_i;
    logic [1:0]  q_i;
    logic        ge;
    if (k == 0) begin : g_first
      assign r_i = {ang_a, 12'd0};
      assign q_i = 2'd0;
    end else begin : g_next
      assign r_i = an_r[k-1];
      assign q_i = an_q[k-1];
    end
    assign ge = r_i >= REDUCE_K[k];
    always_ff @(posedge clk) begin
      if (en) begin
        an_r[k] <= ge ? r_i - REDUCE_K[k] : r_i;
        an_q[k] <= {q_i[0], ge};
      end
    end
  end

  ang_t        f_r;
  logic [29:0] f2_r;
  logic [57:0] ff_full;
  // quadrant waits out the sine-cosine latency
  logic [1:0]  qd [SC_LAT+1];
  q28_t        sin_f, cos_f;

  assign ff_full = an_r[REDUCE_STEPS-1][28:0] * an_r[REDUCE_STEPS-1][28:0];

  always_ff @(posedge clk) begin
    if (en) begin
      f_r   <= an_r[REDUCE_STEPS-1][28:0];
      f2_r  <= ff_full[57:28];
      qd[0] <= an_q[REDUCE_STEPS-1];
      for (int b = 1; b <= SC_LAT; b++) qd[b] <= qd[b-1];
    end
  end

  rvm_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .f     (f_r),
    .f2    (f2_r),
    .sin_f (sin_f),
    .cos_f (cos_f)
  );

  // small-angle flag rides along with the angle path
  localparam int unsigned ID_DLY = REDUCE_STEPS + 1 + SC_LAT + 1;
  logic id_line [ID_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      id_line[0] <= sr_id[SQRT_STEPS-1];
      for (int b = 1; b < ID_DLY; b++) id_line[b] <= id_line[b-1];
    end
  end

  q28_t sn_f, cs_f;

  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[SC_LAT])
        2'd0: begin
          sn_f <= sin_f;
          cs_f <= cos_f;
        end
        2'd1: begin
          sn_f <= cos_f;
          cs_f <= -sin_f;
        end
        2'd2: begin
          sn_f <= -sin_f;
          cs_f <= -cos_f;
        end
        default: begin
          sn_f <= -cos_f;
          cs_f <= sin_f;
        end
      endcase
    end
  end

  // matrix: u*u^T, then (1-cos) scaling, then sums in Q56
  logic signed [31:0] uu_full [6];
  logic signed [31:0] uu0     [6];
  logic signed [45:0] su_full [3];
  logic signed [45:0] su0     [3];
  logic signed [45:0] su1     [3];
  logic signed [30:0] omc_w;
  logic signed [30:0] omc0;
  q28_t               cs0, cs1;
  logic               id0, id1, id2;
  logic signed [62:0] e_full  [6];
  logic signed [59:0] e1      [6];
  logic signed [61:0] sm      [9];
  logic signed [61:0] sm_r    [9];

  assign omc_w = 31'(ONE_Q28) - cs_f;

  for (p = 0; p < 6; p++) begin : g_pair
    assign uu_full[p] = ud[PAIR_I[p]][U_DLY-1] * ud[PAIR_J[p]][U_DLY-1];
    assign e_full[p]  = omc0 * uu0[p];
  end

  for (l = 0; l < 3; l++) begin : g_su
    assign su_full[l] = sn_f * ud[l][U_DLY-1];
  end

  assign sm[0] = e1[0] + (cs1 <<< 28);
  assign sm[1] = e1[1] - (su1[2] <<< 14);
  assign sm[2] = e1[2] + (su1[1] <<< 14);
  assign sm[3] = e1[1] + (su1[2] <<< 14);
  assign sm[4] = e1[3] + (cs1 <<< 28);
  assign sm[5] = e1[4] - (su1[0] <<< 14);
  assign sm[6] = e1[2] - (su1[1] <<< 14);
  assign sm[7] = e1[4] + (su1[0] <<< 14);
  assign sm[8] = e1[5] + (cs1 <<< 28);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 6; b++) begin
        uu0[b] <= uu_full[b];
        e1[b]  <= e_full[b][59:0];
      end
      for (int b = 0; b < 3; b++) begin
        su0[b] <= su_full[b];
        su1[b] <= su0[b];
      end
      omc0 <= omc_w;
      cs0  <= cs_f;
      cs1  <= cs0;
      id0  <= id_line[ID_DLY-1];
      id1  <= id0;
      id2  <= id1;
      for (int b = 0; b < 9; b++) sm_r[b] <= sm[b];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      identity_taken <= id2;
      if (id2) begin
        m00 <= UNIT_Q14;
        m01 <= '0;
        m02 <= '0;
        m10 <= '0;
        m11 <= UNIT_Q14;
        m12 <= '0;
        m20 <= '0;
        m21 <= '0;
        m22 <= UNIT_Q14;
      end else begin
        m00 <= to_q14(sm_r[0]);
        m01 <= to_q14(sm_r[1]);
        m02 <= to_q14(sm_r[2]);
        m10 <= to_q14(sm_r[3]);
        m11 <= to_q14(sm_r[4]);
        m12 <= to_q14(sm_r[5]);
        m20 <= to_q14(sm_r[6]);
        m21 <= to_q14(sm_r[7]);
        m22 <= to_q14(sm_r[8]);
      end
    end
  end

endmodule
